// ===== rtl/kvri_pkg.sv =====
// Shared types, constants and codes of the k-vector range index.
`default_nettype none
package kvri_pkg;

  localparam int MAX_BINS     = 4096;
  localparam int MAX_VALUES   = 1048576;
  localparam int QUERY_MARGIN = 10737;

  localparam int VAL_W       = 32;
  localparam int IBW_W       = 40;
  localparam int BC_W        = 13;
  localparam int BIN_W       = $clog2(MAX_BINS + 1);
  localparam int CNT_W       = $clog2(MAX_VALUES + 1);
  localparam int TABLE_DEPTH = MAX_BINS + 1;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 64;

  // Register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_MIN_VALUE     = 2'd0;
  localparam logic [1:0] REG_MAX_VALUE     = 2'd1;
  localparam logic [1:0] REG_BIN_COUNT     = 2'd2;
  localparam logic [1:0] REG_INV_BIN_WIDTH = 2'd3;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEAL   = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_UNSEALED = 2'd3
  } status_t;

  typedef struct packed {
    logic [VAL_W-1:0] min_value;
    logic [VAL_W-1:0] max_value;
    logic [BIN_W-1:0] eff_bins;
    logic [IBW_W-1:0] inv_bin_width;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] distance;
  } bin_req_t;

  typedef struct packed {
    logic             done;
    logic [BIN_W-1:0] bin;
  } bin_rsp_t;

  typedef struct packed {
    logic             we;
    logic [BIN_W-1:0] addr;
    logic [CNT_W-1:0] data;
  } ram_wr_t;

endpackage
`default_nettype wire

// ===== rtl/kvri_cfg_regs.sv =====
// APB register file holding the index configuration.
`default_nettype none
module kvri_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kvri_pkg::APB_AW-1:0] paddr,
  input  logic [kvri_pkg::APB_DW-1:0] pwdata,
  output logic [kvri_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output kvri_pkg::cfg_t              cfg
);

  logic [kvri_pkg::VAL_W-1:0] min_value;
  logic [kvri_pkg::VAL_W-1:0] max_value;
  logic [kvri_pkg::BC_W-1:0]  bin_count;
  logic [kvri_pkg::IBW_W-1:0] inv_bin_width;
  logic [1:0]                 reg_index;
  logic                       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:3];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value     <= '0;
      max_value     <= 32'd3373259426;
      bin_count     <= kvri_pkg::BC_W'(4096);
      inv_bin_width <= kvri_pkg::IBW_W'(85445653);
    end else if (wr_en) begin
      unique case (reg_index)
        kvri_pkg::REG_MIN_VALUE:     min_value     <= pwdata[kvri_pkg::VAL_W-1:0];
        kvri_pkg::REG_MAX_VALUE:     max_value     <= pwdata[kvri_pkg::VAL_W-1:0];
        kvri_pkg::REG_BIN_COUNT:     bin_count     <= pwdata[kvri_pkg::BC_W-1:0];
        kvri_pkg::REG_INV_BIN_WIDTH: inv_bin_width <= pwdata[kvri_pkg::IBW_W-1:0];
        default:                     min_value     <= min_value;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      kvri_pkg::REG_MIN_VALUE:     prdata = kvri_pkg::APB_DW'(min_value);
      kvri_pkg::REG_MAX_VALUE:     prdata = kvri_pkg::APB_DW'(max_value);
      kvri_pkg::REG_BIN_COUNT:     prdata = kvri_pkg::APB_DW'(bin_count);
      kvri_pkg::REG_INV_BIN_WIDTH: prdata = kvri_pkg::APB_DW'(inv_bin_width);
      default:                     prdata = '0;
    endcase
  end

  // The bin count in use is held within one and MAX_BINS.
  always_comb begin
    cfg.min_value     = min_value;
    cfg.max_value     = max_value;
    cfg.inv_bin_width = inv_bin_width;
    if (bin_count == '0) begin
      cfg.eff_bins = kvri_pkg::BIN_W'(1);
    end else if (32'(bin_count) > kvri_pkg::MAX_BINS) begin
      cfg.eff_bins = kvri_pkg::BIN_W'(kvri_pkg::MAX_BINS);
    end else begin
      cfg.eff_bins = kvri_pkg::BIN_W'(bin_count);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kvri_bin_unit.sv =====
// Pipelined bin calculator: ceiling of distance times inverse bin width, saturated.
`default_nettype none
module kvri_bin_unit (
  input  logic               clk,
  input  logic               rst,
  input  kvri_pkg::bin_req_t req,
  input  kvri_pkg::cfg_t     cfg,
  output kvri_pkg::bin_rsp_t rsp
);

  logic [3:0]                 stage_v;
  logic [kvri_pkg::VAL_W-1:0] distance;
  logic [63:0]                prod_lo;
  logic [39:0]                prod_hi;
  logic [40:0]                mid;
  logic                       sticky;
  logic [kvri_pkg::BIN_W-1:0] bin;
  logic [27:0]                quot_ceil;
  logic [kvri_pkg::BIN_W-1:0] bin_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
    end else begin
      stage_v <= {stage_v[2:0], req.start};
    end
  end

  // The 72-bit product is built from a 32x32 and a 32x8 partial product.
  always_ff @(posedge clk) begin
    if (req.start) begin
      distance <= req.distance;
    end
    prod_lo <= 64'(distance) * 64'(cfg.inv_bin_width[31:0]);
    prod_hi <= 40'(distance) * 40'(cfg.inv_bin_width[39:32]);
    mid     <= 41'(prod_lo[63:32]) + 41'(prod_hi);
    sticky  <= |prod_lo[31:0];
    bin     <= bin_next;
  end

  // Rounds up whenever any of the 46 fraction bits is set.
  always_comb begin
    quot_ceil = 28'(mid[40:14]) + 28'(sticky || (|mid[13:0]));
    if (quot_ceil > 28'(cfg.eff_bins)) begin
      bin_next = cfg.eff_bins;
    end else begin
      bin_next = kvri_pkg::BIN_W'(quot_ceil);
    end
  end

  assign rsp.done = stage_v[3];
  assign rsp.bin  = bin;

endmodule
`default_nettype wire

// ===== rtl/kvri_bin_ram.sv =====
// Bin table memory: one write port, one registered read port.
`default_nettype none
module kvri_bin_ram (
  input  logic                       clk,
  input  kvri_pkg::ram_wr_t          wr,
  input  logic [kvri_pkg::BIN_W-1:0] raddr,
  output logic [kvri_pkg::CNT_W-1:0] rdata
);

  logic [kvri_pkg::CNT_W-1:0] mem [kvri_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/kvector_range_index.sv =====
// An insert presents its result once its bin is computed and the bins it passes are written;
// a rejected insert is answered without a bin. A seal fills the bins left up to the last in use.
// One item is in work at a time; the next can be taken in the cycle the result is first presented.
// The work runs through the four-stage bin multiplier, used twice by a query, and the fill loop.
// Synchronous reset clears the build state and restores the default configuration; the bin
// table is not cleared.
`default_nettype none
module kvector_range_index (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kvri_pkg::APB_AW-1:0] paddr,
  input  logic [kvri_pkg::APB_DW-1:0] pwdata,
  output logic [kvri_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [kvri_pkg::VAL_W-1:0]  value,
  input  logic [kvri_pkg::VAL_W-1:0]  query_low,
  input  logic [kvri_pkg::VAL_W-1:0]  query_high,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [kvri_pkg::CNT_W-1:0]  lower_index,
  output logic [kvri_pkg::CNT_W-1:0]  upper_index,
  output logic [kvri_pkg::CNT_W-1:0]  item_count
);

  localparam int QW = kvri_pkg::VAL_W + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_INS_BIN,
    S_FILL,
    S_Q_CLAMP,
    S_Q_CHECK,
    S_Q_BINL,
    S_Q_BINH,
    S_Q_RDL,
    S_Q_RDU,
    S_DONE
  } state_t;

  state_t                     state;
  kvri_pkg::cfg_t             cfg;
  kvri_pkg::bin_req_t         bin_req;
  kvri_pkg::bin_rsp_t         bin_rsp;
  kvri_pkg::ram_wr_t          ram_wr;
  logic [kvri_pkg::BIN_W-1:0] ram_raddr;
  logic [kvri_pkg::CNT_W-1:0] ram_rdata;

  logic [kvri_pkg::VAL_W-1:0] val;
  logic [kvri_pkg::VAL_W-1:0] qlo;
  logic [kvri_pkg::VAL_W-1:0] qhi;
  logic signed [QW-1:0]       qlo_c;
  logic signed [QW-1:0]       qhi_c;
  logic [kvri_pkg::BIN_W-1:0] lower_bin;
  logic [kvri_pkg::BIN_W-1:0] upper_bin;

  logic [kvri_pkg::CNT_W-1:0] value_count;
  logic [kvri_pkg::BIN_W-1:0] previous_bin;
  logic [kvri_pkg::VAL_W-1:0] previous_value;
  logic                       sealed;

  logic [kvri_pkg::BIN_W-1:0] fill_addr;
  logic [kvri_pkg::BIN_W-1:0] fill_end;
  logic [kvri_pkg::CNT_W-1:0] fill_data;

  kvri_pkg::status_t          res_status;
  logic [kvri_pkg::CNT_W-1:0] res_lower;
  logic [kvri_pkg::CNT_W-1:0] res_upper;

  logic                       ins_reject;
  logic signed [QW-1:0]       qlo_clamp;
  logic signed [QW-1:0]       qhi_clamp;
  logic signed [QW-1:0]       min_s;
  logic signed [QW-1:0]       max_s;
  logic                       q_empty;
  logic [kvri_pkg::CNT_W-1:0] lower_idx;

  kvri_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kvri_bin_unit u_bin (
    .clk (clk),
    .rst (rst),
    .req (bin_req),
    .cfg (cfg),
    .rsp (bin_rsp)
  );

  kvri_bin_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);

  assign ins_reject = (val < cfg.min_value) || (val > cfg.max_value) ||
                      ((value_count != '0) && (val < previous_value)) ||
                      (32'(value_count) >= kvri_pkg::MAX_VALUES);

  assign min_s = $signed({2'b00, cfg.min_value});
  assign max_s = $signed({2'b00, cfg.max_value});

  // Bounds are pulled inward by the margin where they reach the indexed span.
  always_comb begin
    if (qhi >= cfg.max_value) begin
      qhi_clamp = max_s - QW'(kvri_pkg::QUERY_MARGIN);
    end else begin
      qhi_clamp = $signed({2'b00, qhi});
    end
    if (qlo <= cfg.min_value) begin
      qlo_clamp = min_s + QW'(kvri_pkg::QUERY_MARGIN);
    end else begin
      qlo_clamp = $signed({2'b00, qlo});
    end
  end

  assign q_empty   = (qlo_c > max_s) || (qhi_c < min_s) || (qlo_c > qhi_c);
  assign lower_idx = (lower_bin == '0) ? '0 : ram_rdata;

  always_comb begin
    bin_req.start    = 1'b0;
    bin_req.distance = '0;
    unique case (state)
      S_INS: begin
        bin_req.start    = !ins_reject;
        bin_req.distance = val - cfg.min_value;
      end
      S_Q_CHECK: begin
        bin_req.start    = !q_empty;
        bin_req.distance = qlo_c[kvri_pkg::VAL_W-1:0] - cfg.min_value;
      end
      S_Q_BINL: begin
        bin_req.start    = bin_rsp.done;
        bin_req.distance = qhi_c[kvri_pkg::VAL_W-1:0] - cfg.min_value;
      end
      default: begin
        bin_req.start = 1'b0;
      end
    endcase
  end

  assign ram_wr.we   = (state == S_FILL) && (fill_addr < fill_end);
  assign ram_wr.addr = fill_addr;
  assign ram_wr.data = fill_data;

  // The lower entry is read while the upper bin is computed, the upper one after it.
  always_comb begin
    if (state == S_Q_BINH) begin
      ram_raddr = (lower_bin == '0) ? '0 : lower_bin - kvri_pkg::BIN_W'(1);
    end else begin
      ram_raddr = upper_bin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      value_count    <= '0;
      previous_bin   <= '0;
      previous_value <= '0;
      sealed         <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            val        <= value;
            qlo        <= query_low;
            qhi        <= query_high;
            res_status <= kvri_pkg::ST_OK;
            res_lower  <= '0;
            res_upper  <= '0;
            unique case (kvri_pkg::action_t'(action))
              kvri_pkg::ACT_INSERT: begin
                // An insert after sealing starts a fresh build.
                if (sealed) begin
                  value_count    <= '0;
                  previous_bin   <= '0;
                  previous_value <= '0;
                  sealed         <= 1'b0;
                end
                state <= S_INS;
              end
              kvri_pkg::ACT_SEAL: begin
                fill_addr <= previous_bin;
                fill_end  <= cfg.eff_bins + kvri_pkg::BIN_W'(1);
                fill_data <= value_count;
                sealed    <= 1'b1;
                state     <= S_FILL;
              end
              kvri_pkg::ACT_QUERY: state <= S_Q_CLAMP;
              kvri_pkg::ACT_NOP:   state <= S_DONE;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_INS: begin
          if (ins_reject) begin
            res_status <= kvri_pkg::ST_REJECT;
            state      <= S_DONE;
          end else begin
            state <= S_INS_BIN;
          end
        end
        S_INS_BIN: begin
          if (bin_rsp.done) begin
            fill_data      <= value_count;
            value_count    <= value_count + kvri_pkg::CNT_W'(1);
            previous_value <= val;
            if (bin_rsp.bin > previous_bin) begin
              fill_addr    <= previous_bin;
              fill_end     <= bin_rsp.bin;
              previous_bin <= bin_rsp.bin;
              state        <= S_FILL;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_FILL: begin
          if (fill_addr < fill_end) begin
            fill_addr <= fill_addr + kvri_pkg::BIN_W'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_Q_CLAMP: begin
          priority if (!sealed) begin
            res_status <= kvri_pkg::ST_UNSEALED;
            state      <= S_DONE;
          end else if (qhi <= qlo) begin
            res_status <= kvri_pkg::ST_EMPTY;
            state      <= S_DONE;
          end else begin
            qlo_c <= qlo_clamp;
            qhi_c <= qhi_clamp;
            state <= S_Q_CHECK;
          end
        end
        S_Q_CHECK: begin
          if (q_empty) begin
            res_status <= kvri_pkg::ST_EMPTY;
            state      <= S_DONE;
          end else begin
            state <= S_Q_BINL;
          end
        end
        S_Q_BINL: begin
          if (bin_rsp.done) begin
            lower_bin <= bin_rsp.bin;
            state     <= S_Q_BINH;
          end
        end
        S_Q_BINH: begin
          if (bin_rsp.done) begin
            upper_bin <= bin_rsp.bin;
            state     <= S_Q_RDL;
          end
        end
        S_Q_RDL: begin
          if (lower_idx >= value_count) begin
            res_status <= kvri_pkg::ST_EMPTY;
            state      <= S_DONE;
          end else begin
            res_lower <= lower_idx;
            state     <= S_Q_RDU;
          end
        end
        S_Q_RDU: begin
          res_upper <= ram_rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            lower_index <= res_lower;
            upper_index <= res_upper;
            item_count  <= value_count;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(lower_index) &&
                                $stable(upper_index) && $stable(item_count));

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready);

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    ram_wr.we |-> 32'(ram_wr.addr) <= kvri_pkg::MAX_BINS);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(value_count) <= kvri_pkg::MAX_VALUES);

endmodule
`default_nettype wire

// ===== sim/kvri_response_check.sv =====
// Passive checker for the k-vector range index: predicts every result and compares it.
module kvri_response_check
  import kvri_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        action,
  input  logic [VAL_W-1:0]  value,
  input  logic [VAL_W-1:0]  query_low,
  input  logic [VAL_W-1:0]  query_high,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        status,
  input  logic [CNT_W-1:0]  lower_index,
  input  logic [CNT_W-1:0]  upper_index,
  input  logic [CNT_W-1:0]  item_count,
  output int                mismatches,
  output int                awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    action_t          act;
    status_t          st;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [CNT_W-1:0] cnt;
  } range_result_t;

  range_result_t    awaited_q[$];
  logic [CNT_W-1:0] kvec_bins [0:TABLE_DEPTH-1];
  logic [CNT_W-1:0] built_count;
  logic [BIN_W-1:0] last_bin;
  logic [VAL_W-1:0] last_value;
  logic             is_sealed;
  logic [VAL_W-1:0] lo_limit;
  logic [VAL_W-1:0] hi_limit;
  logic [BC_W-1:0]  bins_reg;
  logic [IBW_W-1:0] ibw_reg;
  int               mismatch_total = 0;
  int               result_no = 0;

  task automatic report_mismatch(input string what);
    $display("%0t kvri mismatch: %s", $time, what);
    mismatch_total++;
  endtask

  function automatic logic [BIN_W-1:0] used_bins();
    if (bins_reg == '0) return BIN_W'(1);
    if (bins_reg > MAX_BINS) return BIN_W'(MAX_BINS);
    return bins_reg[BIN_W-1:0];
  endfunction

  // Rounds the full-width product upwards before saturating to the bins in use.
  function automatic logic [BIN_W-1:0] bin_of_distance(input logic [VAL_W-1:0] d);
    logic [VAL_W+IBW_W-1:0] prod;
    logic [VAL_W+IBW_W-46:0] q;
    prod = d * ibw_reg;
    q = prod[VAL_W+IBW_W-1:46];
    if (prod[45:0] != '0) q = q + 1'b1;
    if (q > used_bins()) return used_bins();
    return q[BIN_W-1:0];
  endfunction

  function automatic void fill_bins(input int from, input int upto,
                                    input logic [CNT_W-1:0] count);
    for (int b = from; b < upto && b <= MAX_BINS; b++) kvec_bins[b] = count;
  endfunction

  function automatic range_result_t predict_step(input action_t act,
                                                 input logic [VAL_W-1:0] v, ql_in, qh_in);
    range_result_t    r;
    logic [BIN_W-1:0] b;
    logic [BIN_W-1:0] lb;
    logic [BIN_W-1:0] ub;
    logic [CNT_W-1:0] li;
    longint           ql;
    longint           qh;
    longint           mn;
    longint           mx;
    r.act = act;
    r.st  = ST_OK;
    r.lo  = '0;
    r.hi  = '0;
    case (act)
      ACT_INSERT: begin
        // An insert after sealing opens a fresh build, even if it is rejected.
        if (is_sealed) begin
          built_count = '0;
          last_bin    = '0;
          last_value  = '0;
          is_sealed   = 1'b0;
        end
        if (v < lo_limit || v > hi_limit || (built_count != 0 && v < last_value) ||
            built_count >= MAX_VALUES) begin
          r.st = ST_REJECT;
        end else begin
          b = bin_of_distance(v - lo_limit);
          if (b > last_bin) begin
            fill_bins(last_bin, b, built_count);
            last_bin = b;
          end
          last_value  = v;
          built_count = built_count + 1'b1;
        end
      end
      ACT_SEAL: begin
        fill_bins(last_bin, used_bins() + 1, built_count);
        is_sealed = 1'b1;
      end
      ACT_QUERY: begin
        ql = longint'(ql_in);
        qh = longint'(qh_in);
        mn = longint'(lo_limit);
        mx = longint'(hi_limit);
        if (!is_sealed) begin
          r.st = ST_UNSEALED;
        end else if (qh <= ql) begin
          r.st = ST_EMPTY;
        end else begin
          if (qh >= mx) qh = mx - QUERY_MARGIN;
          if (ql <= mn) ql = mn + QUERY_MARGIN;
          if (ql > mx || qh < mn || ql > qh) begin
            r.st = ST_EMPTY;
          end else begin
            lb = bin_of_distance(VAL_W'(ql - mn));
            ub = bin_of_distance(VAL_W'(qh - mn));
            li = (lb == 0) ? '0 : kvec_bins[lb - 1];
            if (li >= built_count) begin
              r.st = ST_EMPTY;
            end else begin
              r.lo = li;
              r.hi = kvec_bins[ub];
            end
          end
        end
      end
      default: ;
    endcase
    r.cnt = built_count;
    return r;
  endfunction

  always @(posedge clk) begin
    range_result_t want;
    if (rst) begin
      lo_limit    = '0;
      hi_limit    = 32'd3373259426;
      bins_reg    = BC_W'(MAX_BINS);
      ibw_reg     = 40'd85445653;
      built_count = '0;
      last_bin    = '0;
      last_value  = '0;
      is_sealed   = 1'b0;
      awaited_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:3])
          REG_MIN_VALUE:     lo_limit = pwdata[VAL_W-1:0];
          REG_MAX_VALUE:     hi_limit = pwdata[VAL_W-1:0];
          REG_BIN_COUNT:     bins_reg = pwdata[BC_W-1:0];
          REG_INV_BIN_WIDTH: ibw_reg  = pwdata[IBW_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        result_no++;
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item outstanding", result_no));
        end else begin
          want = awaited_q.pop_front();
          if (status !== want.st)
            report_mismatch($sformatf("result %0d (%s): status %0d, expected %0d",
                                      result_no, want.act.name(), status, want.st));
          if (lower_index !== want.lo)
            report_mismatch($sformatf("result %0d (%s): lower_index %0d, expected %0d",
                                      result_no, want.act.name(), lower_index, want.lo));
          if (upper_index !== want.hi)
            report_mismatch($sformatf("result %0d (%s): upper_index %0d, expected %0d",
                                      result_no, want.act.name(), upper_index, want.hi));
          if (item_count !== want.cnt)
            report_mismatch($sformatf("result %0d (%s): item_count %0d, expected %0d",
                                      result_no, want.act.name(), item_count, want.cnt));
        end
      end
      if (in_valid && in_ready)
        awaited_q = {awaited_q, predict_step(action_t'(action), value, query_low, query_high)};
    end
    awaited    <= awaited_q.size();
    mismatches <= mismatch_total;
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the k-vector range index testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kvri_pkg::*;

  localparam int STALL_LIMIT = 50000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        action = '0;
  logic [VAL_W-1:0]  value = '0;
  logic [VAL_W-1:0]  query_low = '0;
  logic [VAL_W-1:0]  query_high = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  logic [CNT_W-1:0]  lower_index;
  logic [CNT_W-1:0]  upper_index;
  logic [CNT_W-1:0]  item_count;
  int                mismatches;
  int                awaited;
  int                stall_cycles = 0;
  bit                steady = 1'b0;
  logic [VAL_W-1:0]  cur_min = '0;
  logic [VAL_W-1:0]  cur_max = 32'd3373259426;

  kvector_range_index dut (.*);

  kvri_response_check u_check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= steady || ($urandom_range(0, 99) >= 23);

  // Counts cycles in which neither channel nor the register port moves anything.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand_upto(input logic [63:0] limit);
    return {$urandom, $urandom} % (limit + 64'd1);
  endfunction

  function automatic logic [VAL_W-1:0] rand_between(input logic [VAL_W-1:0] lo, hi);
    return (hi <= lo) ? lo : lo + VAL_W'(rand_upto(64'(hi - lo)));
  endfunction

  task automatic send_item(input action_t act, input logic [VAL_W-1:0] v, ql, qh);
    while (!steady && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    value      <= v;
    query_low  <= ql;
    query_high <= qh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly ascending builds with random content, most of them sealed and each then queried,
  // with rejected values, idle actions and early queries mixed in.
  task automatic random_traffic(input int n);
    int               sent;
    int               len;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] ql;
    logic [VAL_W-1:0] qh;
    logic [63:0]      span;
    logic [63:0]      stride;
    logic [63:0]      nxt;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      span = (cur_max >= cur_min) ? {32'b0, cur_max} - {32'b0, cur_min} : 64'd0;
      stride = span / (len + 1);
      v = cur_min + VAL_W'(rand_upto(stride));
      for (int k = 0; k < len; k++) begin
        // The first item of a build is always an insert, so a sealed table never outlives it.
        if (k > 0 && $urandom_range(0, 99) < 10) begin
          case ($urandom_range(0, 4))
            0: send_item(ACT_INSERT, v - $urandom_range(1, 1000), $urandom, $urandom);
            1: send_item(ACT_INSERT, $urandom, $urandom, $urandom);
            2: send_item(ACT_INSERT, cur_max + $urandom_range(1, 5000), $urandom, $urandom);
            3: send_item(ACT_NOP, $urandom, $urandom, $urandom);
            default: send_item(ACT_QUERY, $urandom, rand_between(cur_min, v),
                               rand_between(v, cur_max));
          endcase
        end else begin
          send_item(ACT_INSERT, v, $urandom, $urandom);
          nxt = {32'b0, v} + (($urandom_range(0, 99) < 15) ? 64'd0 : rand_upto(stride));
          v = (nxt > {32'b0, cur_max}) ? cur_max : nxt[VAL_W-1:0];
        end
        sent++;
      end
      if ($urandom_range(0, 99) < 92) begin
        send_item(ACT_SEAL, $urandom, $urandom, $urandom);
        sent++;
        if ($urandom_range(0, 9) == 0) begin
          send_item(ACT_SEAL, $urandom, $urandom, $urandom);
          sent++;
        end
      end
      repeat ($urandom_range(2, 8)) begin
        a = rand_between(cur_min, cur_max);
        b = rand_between(cur_min, cur_max);
        ql = (a < b) ? a : b;
        qh = (a < b) ? b : a;
        case ($urandom_range(0, 9))
          6: begin
            ql = '0;
            qh = '1;
          end
          7: begin
            ql = $urandom;
            qh = $urandom;
          end
          8: begin
            ql = (a < b) ? b : a;
            qh = (a < b) ? a : b;
          end
          9: begin
            ql = cur_min - $urandom_range(0, 20000);
            qh = cur_min + $urandom_range(0, 40000);
          end
          default: ;
        endcase
        send_item(ACT_QUERY, $urandom, ql, qh);
        sent++;
      end
    end
  endtask

  initial begin
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [BC_W-1:0]  nb;
    logic [IBW_W-1:0] ibw;
    logic [63:0]      span;
    logic [63:0]      fit;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset configuration.
    send_item(ACT_QUERY, '0, '0, '1);
    send_item(ACT_NOP, '1, '1, '1);
    send_item(ACT_SEAL, '0, '0, '0);
    send_item(ACT_QUERY, '0, '0, '1);
    send_item(ACT_INSERT, '0, '0, '0);
    send_item(ACT_INSERT, '0, '0, '0);
    send_item(ACT_INSERT, 32'd1000, '0, '0);
    send_item(ACT_INSERT, 32'd500, '0, '0);
    send_item(ACT_INSERT, '1, '0, '0);
    send_item(ACT_INSERT, 32'h4000_0000, '0, '0);
    send_item(ACT_INSERT, 32'd3373259426, '0, '0);
    send_item(ACT_QUERY, '0, 32'h1000_0000, 32'h5000_0000);
    send_item(ACT_SEAL, '0, '0, '0);
    send_item(ACT_SEAL, '0, '0, '0);
    send_item(ACT_QUERY, '0, '0, '1);
    send_item(ACT_QUERY, '0, 32'h2000_0000, 32'h2000_0000);
    send_item(ACT_QUERY, '0, 32'h8000_0000, 32'h1000_0000);
    send_item(ACT_QUERY, '0, 32'hCA00_0000, '1);
    send_item(ACT_QUERY, '0, '0, 32'd1);
    send_item(ACT_QUERY, '0, 32'h3FFF_0000, 32'h4001_0000);
    send_item(ACT_QUERY, '0, 32'h5000_0000, 32'h6000_0000);
    send_item(ACT_INSERT, 32'd100, '0, '0);
    send_item(ACT_INSERT, 32'd200, '0, '0);
    send_item(ACT_SEAL, '0, '0, '0);
    send_item(ACT_QUERY, '0, 32'h8000_0000, 32'hA000_0000);
    random_traffic(45);

    for (int p = 1; p <= 9; p++) begin
      wait_idle();
      lo = $urandom_range(0, 32'h4000_0000);
      hi = lo + $urandom_range(32'h0100_0000, 32'hB000_0000);
      nb = $urandom_range(2, 300);
      steady = 1'b0;
      case (p)
        1: begin
          lo = '0;
          hi = '1;
          nb = 13'd16;
        end
        2: nb = 13'd1;
        3: begin
          nb = '0;
          steady = 1'b1;
        end
        4: begin
          lo = '0;
          hi = '1;
          nb = '1;
        end
        5: begin
          lo = '1;
          hi = '0;
          nb = 13'd64;
        end
        9: nb = 13'd4096;
        default: ;
      endcase
      // Bins per unit chosen so that the indexed span covers the bins in use, apart from passes 3 to 5.
      span = (hi >= lo) ? {32'b0, hi} - {32'b0, lo} + 64'd1 : 64'd1;
      fit = ({51'b0, nb} << 46) / span;
      ibw = (fit > 64'hFF_FFFF_FFFF) ? '1 : fit[IBW_W-1:0];
      if (p == 3) ibw = '0;
      if (p == 4) ibw = '1;
      if (p == 5) ibw = {8'($urandom_range(0, 255)), 32'($urandom)};
      write_reg(REG_MIN_VALUE, {32'b0, lo});
      write_reg(REG_MAX_VALUE, {32'b0, hi});
      write_reg(REG_BIN_COUNT, {51'b0, nb});
      write_reg(REG_INV_BIN_WIDTH, {24'b0, ibw});
      cur_min = lo;
      cur_max = hi;
      random_traffic((p == 9) ? 30 : 72);
    end

    wait_idle();
    if (mismatches == 0 && awaited == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kvri_pkg.sv
rtl/kvri_cfg_regs.sv
rtl/kvri_bin_unit.sv
rtl/kvri_bin_ram.sv
rtl/kvector_range_index.sv
sim/kvri_response_check.sv
sim/testbench.sv
